FILE: rtl/bnfa_pkg.sv
// bnfa_pkg: shared types, codes and helpers of the bitmap next-fit allocator
// no dependencies; imported by bnfa_map_ram, bitmap_next_fit_allocator and the test bench
`default_nettype none

package bnfa_pkg;

   // map geometry
   localparam int CAPACITY  = 4096;
   localparam int MAP_BYTES = (CAPACITY + 7) / 8;
   localparam int ADDR_W    = $clog2(MAP_BYTES);
   localparam int NBYTES_W  = $clog2(MAP_BYTES + 1);

   // field widths
   localparam int OP_W     = 3;
   localparam int SLOT_W   = 12;
   localparam int CNT_W    = 13;
   localparam int STATUS_W = 2;
   localparam int CSR_IDX_W = 2;

   // operation codes
   localparam logic [OP_W-1:0] OP_ALLOC   = 3'd0;
   localparam logic [OP_W-1:0] OP_MARK    = 3'd1;
   localparam logic [OP_W-1:0] OP_RELEASE = 3'd2;
   localparam logic [OP_W-1:0] OP_TEST    = 3'd3;
   localparam logic [OP_W-1:0] OP_INIT    = 3'd4;

   // status codes
   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NONE_FREE = 2'd1;
   localparam logic [STATUS_W-1:0] ST_ERROR     = 2'd2;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SIZE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FILL = 2'd1;

   typedef struct packed {
      logic [OP_W-1:0]   operation;
      logic [SLOT_W-1:0] offset;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [SLOT_W-1:0]   slot_index;
      logic                bit_value;
      logic [CNT_W-1:0]    free_count;
   } rsp_type;

   // bits of byte b that lie at or past the size
   function automatic logic [7:0] tail_mask(input logic [ADDR_W-1:0] b,
                                            input logic [CNT_W-1:0] size);
      logic [7:0] m;
      m = '0;
      for (int k = 0; k < 8; k++) begin
         m[k] = (CNT_W'({b, 3'(k)}) >= size);
      end
      return m;
   endfunction

   // index of the lowest clear bit, 7 when none is clear
   function automatic logic [2:0] lowest_clear(input logic [7:0] v);
      logic [2:0] idx;
      idx = 3'd7;
      for (int k = 7; k >= 0; k--) begin
         if (!v[k]) idx = 3'(k);
      end
      return idx;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/bnfa_map_ram.sv
// bnfa_map_ram: byte-wide map memory, one write and one read port
// read data registered; depends on bnfa_pkg
`default_nettype none

module bnfa_map_ram (
   input  wire logic                       clock,
   input  wire logic                       wr_en,
   input  wire logic [bnfa_pkg::ADDR_W-1:0] wr_addr,
   input  wire logic [7:0]                 wr_data,
   input  wire logic [bnfa_pkg::ADDR_W-1:0] rd_addr,
   output logic [7:0]                      rd_data
);
   import bnfa_pkg::*;

   logic [7:0] mem [MAP_BYTES];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port, old data on a same-address collision
   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

FILE: rtl/bitmap_next_fit_allocator.sv
// bitmap_next_fit_allocator: next-fit slot allocator over a byte-stored bitmap
// mark/release/test read, modify and write back the byte; out-of-range and
// unknown ops answer in the cycle after start; allocate scans the map from the hint,
// one map read per cycle; reinitialise writes every byte
// reset: synchronous; the map is swept to all free, busy high
// each result is strobed by rsp_valid for one cycle; the receiver cannot stall
// depends on bnfa_pkg and bnfa_map_ram
`default_nettype none

module bitmap_next_fit_allocator (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // command word in
   input  wire logic                          start,
   output logic                               busy,
   input  wire bnfa_pkg::req_type             req_word,
   // result word out
   output logic                               rsp_valid,
   output bnfa_pkg::rsp_type                  rsp_word,
   // configuration writes
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [bnfa_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [bnfa_pkg::CNT_W-1:0]    csr_data
);
   import bnfa_pkg::*;

   localparam logic [2:0] S_CLEAR  = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_MODIFY = 3'd2;
   localparam logic [2:0] S_SCAN   = 3'd3;
   localparam logic [2:0] S_FILL   = 3'd4;

   logic [2:0]          state_ff, state_in;
   logic [CNT_W-1:0]    size_ff, size_in;
   logic                fill_ff, fill_in;
   logic [SLOT_W-1:0]   hint_ff, hint_in;
   logic [CNT_W-1:0]    free_ff, free_in;
   logic [OP_W-1:0]     op_ff, op_in;
   logic [SLOT_W-1:0]   off_ff, off_in;
   logic [ADDR_W-1:0]   cnt_ff, cnt_in;
   logic [ADDR_W-1:0]   scan_addr_ff, scan_addr_in;
   logic [NBYTES_W-1:0] issue_cnt_ff, issue_cnt_in;
   logic                chk_valid_ff, chk_valid_in;
   logic                chk_last_ff, chk_last_in;
   logic [ADDR_W-1:0]   chk_addr_ff, chk_addr_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_ff, rsp_in;

   logic                wr_en;
   logic [ADDR_W-1:0]   wr_addr;
   logic [7:0]          wr_data;
   logic [ADDR_W-1:0]   rd_addr;
   logic [7:0]          rd_data;

   logic [CNT_W-1:0]    size_eff;
   logic [NBYTES_W-1:0] nbytes;
   logic [SLOT_W-1:0]   hint_eff;
   logic [ADDR_W-1:0]   scan_next;
   logic [7:0]          view;
   logic [2:0]          clr_bit;
   logic [CNT_W-1:0]    slot_next;
   logic                bit_old;

   bnfa_map_ram u_map (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // size clipped to capacity, byte count and hint view
   assign size_eff  = (size_ff > CNT_W'(CAPACITY)) ? CNT_W'(CAPACITY) : size_ff;
   assign nbytes    = NBYTES_W'((size_eff + CNT_W'(7)) >> 3);
   assign hint_eff  = (CNT_W'(hint_ff) >= size_eff) ? '0 : hint_ff;
   assign scan_next = (NBYTES_W'(scan_addr_ff) + NBYTES_W'(1) >= nbytes)
                      ? '0 : scan_addr_ff + ADDR_W'(1);

   // byte under check as the search sees it
   assign view      = rd_data | tail_mask(chk_addr_ff, size_eff);
   assign clr_bit   = lowest_clear(view);
   assign slot_next = CNT_W'({chk_addr_ff, clr_bit}) + CNT_W'(1);
   assign bit_old   = rd_data[off_ff[2:0]];

   // control and datapath
   always_comb begin
      state_in     = state_ff;
      size_in      = size_ff;
      fill_in      = fill_ff;
      hint_in      = hint_ff;
      free_in      = free_ff;
      op_in        = op_ff;
      off_in       = off_ff;
      cnt_in       = cnt_ff;
      scan_addr_in = scan_addr_ff;
      issue_cnt_in = issue_cnt_ff;
      chk_valid_in = chk_valid_ff;
      chk_last_in  = chk_last_ff;
      chk_addr_in  = chk_addr_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      wr_en        = 1'b0;
      wr_addr      = cnt_ff;
      wr_data      = '0;
      rd_addr      = ADDR_W'(req_word.offset >> 3);

      // configuration writes
      if (csr_valid) begin
         case (csr_index)
            CSR_SIZE: size_in = csr_data;
            CSR_FILL: fill_in = csr_data[0];
            default:  ;
         endcase
      end

      case (state_ff)
         // sweep the map to all free after reset
         S_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = cnt_ff;
            wr_data = '0;
            cnt_in  = cnt_ff + ADDR_W'(1);
            if (cnt_ff == ADDR_W'(MAP_BYTES - 1)) begin
               state_in = S_IDLE;
            end
         end

         // take a command word
         S_IDLE: begin
            if (start) begin
               op_in  = req_word.operation;
               off_in = req_word.offset;
               case (req_word.operation) inside
                  OP_ALLOC: begin
                     if (free_ff == '0 || nbytes == '0) begin
                        rsp_valid_in = 1'b1;
                        rsp_in = '{ST_NONE_FREE, '0, 1'b0, free_ff};
                     end else begin
                        scan_addr_in = ADDR_W'(hint_eff >> 3);
                        issue_cnt_in = '0;
                        chk_valid_in = 1'b0;
                        state_in     = S_SCAN;
                     end
                  end
                  OP_MARK, OP_RELEASE, OP_TEST: begin
                     if (CNT_W'(req_word.offset) >= size_eff) begin
                        rsp_valid_in = 1'b1;
                        rsp_in = '{ST_ERROR, req_word.offset, 1'b0, free_ff};
                     end else begin
                        state_in = S_MODIFY;
                     end
                  end
                  OP_INIT: begin
                     cnt_in   = '0;
                     state_in = S_FILL;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                     rsp_in = '{ST_ERROR, req_word.offset, 1'b0, free_ff};
                  end
               endcase
            end
         end

         // read data is back: mark or release one bit and write the byte back, or just report it
         S_MODIFY: begin
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
            wr_addr      = ADDR_W'(off_ff >> 3);
            case (op_ff)
               OP_MARK: begin
                  if (bit_old) begin
                     rsp_in = '{ST_ERROR, off_ff, 1'b1, free_ff};
                  end else begin
                     wr_en   = 1'b1;
                     wr_data = rd_data | (8'd1 << off_ff[2:0]);
                     free_in = (free_ff != '0) ? free_ff - CNT_W'(1) : free_ff;
                     rsp_in  = '{ST_OK, off_ff, 1'b1, free_in};
                  end
               end
               OP_RELEASE: begin
                  if (!bit_old) begin
                     rsp_in = '{ST_ERROR, off_ff, 1'b0, free_ff};
                  end else begin
                     wr_en   = 1'b1;
                     wr_data = rd_data & ~(8'd1 << off_ff[2:0]);
                     free_in = (free_ff < CNT_W'(CAPACITY)) ? free_ff + CNT_W'(1)
                                                              : free_ff;
                     rsp_in  = '{ST_OK, off_ff, 1'b0, free_in};
                  end
               end
               default: begin
                  rsp_in = '{ST_OK, off_ff, bit_old, free_ff};
               end
            endcase
         end

         // one byte read per cycle, checked the cycle after
         S_SCAN: begin
            rd_addr = scan_addr_ff;
            if (chk_valid_ff && view != 8'hff) begin
               wr_en        = 1'b1;
               wr_addr      = chk_addr_ff;
               wr_data      = rd_data | (8'd1 << clr_bit);
               free_in      = free_ff - CNT_W'(1);
               hint_in      = (slot_next >= size_eff) ? '0 : SLOT_W'(slot_next);
               rsp_valid_in = 1'b1;
               rsp_in       = '{ST_OK, SLOT_W'({chk_addr_ff, clr_bit}), 1'b1, free_in};
               state_in     = S_IDLE;
            end else if (chk_valid_ff && chk_last_ff) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '{ST_NONE_FREE, '0, 1'b0, free_ff};
               state_in     = S_IDLE;
            end else if (issue_cnt_ff < nbytes) begin
               chk_valid_in = 1'b1;
               chk_addr_in  = scan_addr_ff;
               chk_last_in  = (issue_cnt_ff == nbytes - NBYTES_W'(1));
               scan_addr_in = scan_next;
               issue_cnt_in = issue_cnt_ff + NBYTES_W'(1);
            end else begin
               chk_valid_in = 1'b0;
            end
         end

         // reinitialise: write every byte, then answer
         S_FILL: begin
            wr_en   = 1'b1;
            wr_addr = cnt_ff;
            wr_data = fill_ff ? 8'hff : tail_mask(cnt_ff, size_eff);
            cnt_in  = cnt_ff + ADDR_W'(1);
            if (cnt_ff == ADDR_W'(MAP_BYTES - 1)) begin
               free_in      = fill_ff ? '0 : size_eff;
               hint_in      = '0;
               rsp_valid_in = 1'b1;
               rsp_in       = '{ST_OK, off_ff,
                                fill_ff | (CNT_W'(off_ff) >= size_eff), free_in};
               state_in     = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         size_ff      <= CNT_W'(4096);
         fill_ff      <= 1'b0;
         hint_ff      <= '0;
         free_ff      <= CNT_W'(CAPACITY);
         cnt_ff       <= '0;
         chk_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         size_ff      <= size_in;
         fill_ff      <= fill_in;
         hint_ff      <= hint_in;
         free_ff      <= free_in;
         cnt_ff       <= cnt_in;
         chk_valid_ff <= chk_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      off_ff       <= off_in;
      scan_addr_ff <= scan_addr_in;
      issue_cnt_ff <= issue_cnt_in;
      chk_last_ff  <= chk_last_in;
      chk_addr_ff  <= chk_addr_in;
      rsp_ff       <= rsp_in;
   end

   assign busy      = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

`ifndef SYNTHESIS
   // a result word comes with the return to idle
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result word while busy");

   // every read-modify-write ends in a result word
   a_modify_rsp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MODIFY) |=> rsp_valid)
      else $error("modify finished without a result word");

   // free count stays within capacity
   a_free_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_word.free_count <= CNT_W'(CAPACITY)))
      else $error("free count above capacity");
`endif

endmodule

`default_nettype wire

FILE: tb/bitmap_next_fit_allocator_test.sv
// bitmap_next_fit_allocator_test: self-checking bench for the next-fit slot allocator
// drives directed and random command words, predicts each result word from its own map copy
// depends on bnfa_pkg and bitmap_next_fit_allocator

module bitmap_next_fit_allocator_test;
   timeunit 1ns;
   timeprecision 1ps;

   import bnfa_pkg::*;

   // operation codes the block does not define
   localparam logic [OP_W-1:0] OP_UNDEF_5 = 3'd5;
   localparam logic [OP_W-1:0] OP_UNDEF_6 = 3'd6;
   localparam logic [OP_W-1:0] OP_UNDEF_7 = 3'd7;

   localparam int RESET_CYCLES  = 7;
   localparam int CYCLE_LIMIT   = 2_000_000;
   localparam int ITEM_TARGET   = 850;
   localparam int SETTLE_CYCLES = 600;
   localparam int MAX_REPORTS   = 10;
   localparam int SIZE_FIELD_MAX = (1 << CNT_W) - 1;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 start;
   logic                 busy;
   req_type              req_word;
   logic                 rsp_valid;
   rsp_type              rsp_word;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CNT_W-1:0]     csr_data;

   // predicted allocator state
   logic [CAPACITY-1:0]  used_map;
   int                   next_hint;
   int                   free_slots;
   logic [CNT_W-1:0]     size_reg;
   logic                 fill_reg;

   rsp_type              pending_rsp[$];
   int                   mismatch_count = 0;
   int                   items_sent = 0;
   int                   cycle_count = 0;
   bit                   steady;

   always #1 clock = ~clock;

   bitmap_next_fit_allocator i_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // byte as the search sees it: slots at or past the size count as used
   function automatic logic [7:0] search_byte(int b, int size);
      logic [7:0] v;
      v = used_map[b*8 +: 8];
      for (int k = 0; k < 8; k++) begin
         if (b*8 + k >= size) v[k] = 1'b1;
      end
      return v;
   endfunction

   // apply one command word to the predicted map, return the expected result word
   function automatic rsp_type apply_command(req_type w);
      rsp_type    r;
      int         size;
      int         nbytes;
      int         b;
      int         k;
      int         i;
      logic [7:0] v;
      logic       hit;
      size = (int'(size_reg) > CAPACITY) ? CAPACITY : int'(size_reg);
      r.status     = ST_OK;
      r.slot_index = w.offset;
      r.bit_value  = 1'b0;
      v = 8'hff;
      case (w.operation)
         OP_ALLOC: begin
            r.status     = ST_NONE_FREE;
            r.slot_index = '0;
            nbytes = (size + 7) / 8;
            b = ((next_hint >= size) ? 0 : next_hint) / 8;
            hit = 1'b0;
            i = 0;
            // wrap-around byte scan from the hint
            while (free_slots != 0 && !hit && i < nbytes) begin
               v = search_byte(b, size);
               if (v != 8'hff) begin
                  hit = 1'b1;
               end else begin
                  b = (b + 1 == nbytes) ? 0 : b + 1;
                  i++;
               end
            end
            if (hit) begin
               k = 0;
               while (k < 7 && v[k]) k++;
               used_map[b*8 + k] = 1'b1;
               free_slots--;
               next_hint = b*8 + k + 1;
               if (next_hint >= size) next_hint = 0;
               r.status     = ST_OK;
               r.slot_index = SLOT_W'(b*8 + k);
               r.bit_value  = 1'b1;
            end
         end
         OP_MARK, OP_RELEASE, OP_TEST: begin
            if (int'(w.offset) >= size) begin
               r.status = ST_ERROR;
            end else begin
               r.bit_value = used_map[w.offset];
               if (w.operation == OP_MARK) begin
                  if (r.bit_value) begin
                     r.status = ST_ERROR;
                  end else begin
                     used_map[w.offset] = 1'b1;
                     if (free_slots > 0) free_slots--;
                     r.bit_value = 1'b1;
                  end
               end else if (w.operation == OP_RELEASE) begin
                  if (!r.bit_value) begin
                     r.status = ST_ERROR;
                  end else begin
                     used_map[w.offset] = 1'b0;
                     if (free_slots < CAPACITY) free_slots++;
                     r.bit_value = 1'b0;
                  end
               end
            end
         end
         OP_INIT: begin
            if (fill_reg) begin
               used_map   = '1;
               free_slots = 0;
            end else begin
               used_map = '0;
               for (int s = size; s < CAPACITY; s++) used_map[s] = 1'b1;
               free_slots = size;
            end
            next_hint   = 0;
            r.bit_value = used_map[w.offset];
         end
         default: begin
            r.status = ST_ERROR;
         end
      endcase
      r.free_count = CNT_W'(free_slots);
      return r;
   endfunction

   task automatic compare_field(string name, int want, int got);
      if (want != got) begin
         mismatch_count++;
         if (mismatch_count <= MAX_REPORTS)
            $display("mismatch on %s: expected %0d, got %0d", name, want, got);
      end
   endtask

   // result word checker, the receiver never stalls
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (pending_rsp.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("result word with none expected: %h", rsp_word);
         end else begin
            want = pending_rsp.pop_front();
            compare_field("status", want.status, rsp_word.status);
            compare_field("slot_index", want.slot_index, rsp_word.slot_index);
            compare_field("bit_value", want.bit_value, rsp_word.bit_value);
            compare_field("free_count", want.free_count, rsp_word.free_count);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // send one command word, predict its result once accepted
   task automatic send_word(logic [OP_W-1:0] op, logic [SLOT_W-1:0] off);
      req_type w;
      w.operation = op;
      w.offset    = off;
      if (!steady && $urandom_range(0, 99) < 24) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      start    <= 1'b1;
      req_word <= w;
      do @(posedge clock); while (busy);
      pending_rsp.push_back(apply_command(w));
      items_sent++;
   endtask

   // hold off commands until every expected word is back
   task automatic drain_results();
      start <= 1'b0;
      do @(posedge clock); while (pending_rsp.size() != 0);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CNT_W-1:0] data);
      if (!steady && $urandom_range(0, 99) < 24) begin
         csr_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_SIZE) size_reg = data;
      else fill_reg = data[0];
   endtask

   // registers change only with the block idle
   task automatic set_config(int size, bit fill);
      drain_results();
      write_csr(CSR_SIZE, CNT_W'(size));
      write_csr(CSR_FILL, CNT_W'(fill));
      csr_valid <= 1'b0;
   endtask

   // test, mark, release and allocate at the offset extremes, wrong bit states, undefined codes
   task automatic test_basic_ops();
      send_word(OP_TEST, 12'h000);
      send_word(OP_MARK, 12'hfff);
      send_word(OP_MARK, 12'hfff);
      send_word(OP_RELEASE, 12'hfff);
      send_word(OP_RELEASE, 12'hfff);
      send_word(OP_ALLOC, 12'h000);
      send_word(OP_MARK, 12'haaa);
      send_word(OP_RELEASE, 12'h555);
      send_word(OP_UNDEF_5, 12'hfff);
      send_word(OP_UNDEF_6, 12'h000);
      send_word(OP_UNDEF_7, 12'h5a5);
   endtask

   // small map: fill up, hint wrap, then grow the size without reinit
   task automatic test_hint_wrap();
      set_config(4, 1'b0);
      send_word(OP_INIT, 12'h007);
      repeat (5) send_word(OP_ALLOC, 12'h000);
      send_word(OP_TEST, 12'h004);
      set_config(12, 1'b0);
      send_word(OP_RELEASE, 12'h009);
      send_word(OP_ALLOC, 12'h000);
   endtask

   // zero size, size past capacity, all-used fill
   task automatic test_size_extremes();
      set_config(0, 1'b0);
      send_word(OP_ALLOC, 12'h000);
      send_word(OP_TEST, 12'h000);
      set_config(SIZE_FIELD_MAX, 1'b1);
      send_word(OP_INIT, 12'hfff);
      send_word(OP_ALLOC, 12'h000);
      send_word(OP_RELEASE, 12'hfff);
      send_word(OP_ALLOC, 12'h000);
      set_config(CAPACITY + 1, 1'b0);
      send_word(OP_TEST, 12'hfff);
      send_word(OP_INIT, 12'h000);
      send_word(OP_ALLOC, 12'h000);
   endtask

   // random phases: new settings, mostly a reinit, then mixed traffic
   task automatic test_random_traffic();
      int                phase;
      int                size;
      int                span;
      int                count;
      int                roll;
      logic [OP_W-1:0]   op;
      logic [SLOT_W-1:0] off;
      phase = 0;
      while (items_sent < ITEM_TARGET) begin
         roll = $urandom_range(0, 99);
         if (roll < 70) size = $urandom_range(1, 48);
         else if (roll < 80) size = $urandom_range(49, 300);
         else if (roll < 87) size = CAPACITY;
         else if (roll < 91) size = $urandom_range(CAPACITY + 1, SIZE_FIELD_MAX);
         else if (roll < 94) size = 0;
         else size = $urandom_range(301, CAPACITY - 1);
         set_config(size, $urandom_range(0, 1));
         steady = (phase == 3);
         if ($urandom_range(0, 3) != 0) send_word(OP_INIT, SLOT_W'($urandom));
         span  = (size > CAPACITY) ? CAPACITY : size;
         count = (span > 300) ? $urandom_range(8, 16) : $urandom_range(30, 70);
         repeat (count) begin
            roll = $urandom_range(0, 99);
            if (roll < 36) op = OP_ALLOC;
            else if (roll < 52) op = OP_MARK;
            else if (roll < 74) op = OP_RELEASE;
            else if (roll < 88) op = OP_TEST;
            else if (roll < 92) op = OP_INIT;
            else op = OP_W'($urandom_range(OP_UNDEF_5, OP_UNDEF_7));
            // mostly near the managed range, the rest anywhere
            if (span > 0 && $urandom_range(0, 99) < 85)
               off = SLOT_W'($urandom_range(0, (span < CAPACITY) ? span : CAPACITY - 1));
            else
               off = SLOT_W'($urandom);
            send_word(op, off);
         end
         phase++;
      end
      steady = 1'b0;
   endtask

   initial begin
      reset     <= 1'b1;
      start     <= 1'b0;
      req_word  <= '0;
      csr_valid <= 1'b0;
      csr_index <= CSR_SIZE;
      csr_data  <= '0;
      steady     = 1'b0;
      size_reg   = CNT_W'(CAPACITY);
      fill_reg   = 1'b0;
      used_map   = '0;
      next_hint  = 0;
      free_slots = CAPACITY;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      test_basic_ops();
      test_hint_wrap();
      test_size_extremes();
      test_random_traffic();

      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      mismatch_count += pending_rsp.size();
      if (mismatch_count == 0) $display("simulation ok");
      else $display("simulation failed");
      $finish;
   end

endmodule
